// ----- rtl/core/bma_pkg.sv -----
// Package for the blocking moment accumulator: sizes, widths, controller states
// and the command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
package bma_pkg;
	localparam int BANDS_DEF  = 4;
	localparam int DERIVS_DEF = 4;
	localparam int LEVELS_DEF = 16;

	localparam int SAMPLE_W = 32;
	localparam int STEP_W   = 31;
	localparam int SQ_W     = 63;
	localparam int LEVEL_W  = 4;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_IDLE,
		CMD_LOAD,
		CMD_READ,
		CMD_PBM,
		CMD_FM,
		CMD_SM,
		CMD_WRITE,
		CMD_EMIT
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_PBM,
		ST_PBM_W,
		ST_FM,
		ST_FM_W,
		ST_SM,
		ST_SM_W,
		ST_WRITE,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		cmd_t cmd;
		logic div_start;
		logic clr_write;
		logic next_level;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic closed;
		logic last_lvl;
		logic out_busy;
		logic clr_last;
	} sts_t;
endpackage

// ----- rtl/core/bma_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module bma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/core/bma_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Dividend 66 bits signed, divisor 32 bits unsigned and nonzero. Depends on nothing.
`timescale 1ns / 1ps
module bma_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [65:0] dividend,
	input  logic [31:0]        divisor,
	output logic signed [65:0] quotient,
	output logic               done
);
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [64:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic [65:0] mag;

	assign mag   = dividend[65] ? -dividend : dividend;
	assign trial = {rem_q[31:0], quo_q[64]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd65;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag[64:0];
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[65];
		end else if (busy_q) begin
			// restoring step: shift in next dividend bit, keep trial if non-negative
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[63:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[64]};
				quo_q <= {quo_q[63:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ----- rtl/core/bma_ctrl.sv -----
// Controller state machine: sequences the levels of one item through the datapath.
// Depends on bma_pkg.
`timescale 1ns / 1ps
module bma_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             in_ok,
	input  bma_pkg::sts_t    sts,
	output bma_pkg::ctl_t    ctl,
	output logic             idle
);
	bma_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bma_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '{cmd: bma_pkg::CMD_IDLE, div_start: 1'b0, clr_write: 1'b0,
			next_level: 1'b0};
		idle    = 1'b0;
		unique case (state_q)
			bma_pkg::ST_CLEAR: begin
				ctl.clr_write = 1'b1;
				if (sts.clr_last) begin
					state_d = bma_pkg::ST_IDLE;
				end
			end
			bma_pkg::ST_IDLE: begin
				idle    = 1'b1;
				ctl.cmd = bma_pkg::CMD_LOAD;
				if (in_fire && in_ok) begin
					state_d = bma_pkg::ST_READ;
				end
			end
			bma_pkg::ST_READ: begin
				ctl.cmd = bma_pkg::CMD_READ;
				state_d = bma_pkg::ST_WAIT;
			end
			bma_pkg::ST_WAIT: begin
				state_d = bma_pkg::ST_PBM;
			end
			bma_pkg::ST_PBM: begin
				ctl.div_start = 1'b1;
				ctl.cmd       = bma_pkg::CMD_IDLE;
				state_d       = bma_pkg::ST_PBM_W;
			end
			bma_pkg::ST_PBM_W: begin
				if (sts.div_done) begin
					ctl.cmd = bma_pkg::CMD_PBM;
					state_d = sts.closed ? bma_pkg::ST_FM : bma_pkg::ST_WRITE;
				end
			end
			bma_pkg::ST_FM: begin
				ctl.div_start = 1'b1;
				state_d       = bma_pkg::ST_FM_W;
			end
			bma_pkg::ST_FM_W: begin
				if (sts.div_done) begin
					ctl.cmd = bma_pkg::CMD_FM;
					state_d = bma_pkg::ST_SM;
				end
			end
			bma_pkg::ST_SM: begin
				ctl.div_start = 1'b1;
				state_d       = bma_pkg::ST_SM_W;
			end
			bma_pkg::ST_SM_W: begin
				if (sts.div_done) begin
					ctl.cmd = bma_pkg::CMD_SM;
					state_d = bma_pkg::ST_WRITE;
				end
			end
			bma_pkg::ST_WRITE: begin
				if (!sts.out_busy) begin
					ctl.cmd = bma_pkg::CMD_WRITE;
					state_d = bma_pkg::ST_EMIT;
				end
			end
			bma_pkg::ST_EMIT: begin
				ctl.next_level = 1'b1;
				state_d = sts.last_lvl ? bma_pkg::ST_IDLE : bma_pkg::ST_READ;
			end
			default: state_d = bma_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_clear_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bma_pkg::ST_CLEAR |-> !ctl.div_start) else $error("div start in clear");
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == bma_pkg::CMD_WRITE |-> !sts.out_busy) else $error("write over busy output");
	a_emit_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bma_pkg::ST_EMIT && !sts.last_lvl |=> state_q == bma_pkg::ST_READ)
		else $error("emit sequencing");
`endif
endmodule

// ----- rtl/core/bma_dp.sv -----
// Datapath: channel state memories, shared divider, result register.
// Depends on bma_pkg, bma_ram, bma_div.
`timescale 1ns / 1ps
module bma_dp #(
	parameter int BANDS  = bma_pkg::BANDS_DEF,
	parameter int DERIVS = bma_pkg::DERIVS_DEF,
	parameter int LEVELS = bma_pkg::LEVELS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bma_pkg::ctl_t          ctl,
	output bma_pkg::sts_t          sts,
	input  logic [1:0]             band_index,
	input  logic [1:0]             deriv_index,
	input  logic [30:0]            step_number,
	input  logic signed [31:0]     sample_value,
	output logic                   in_ok,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             out_level,
	output logic signed [31:0]     out_pbm,
	output logic                   out_closed,
	output logic signed [31:0]     out_fm,
	output logic [62:0]            out_sm,
	output logic                   out_last
);
	localparam int CELLS = BANDS * DERIVS * LEVELS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [30:0]        step_q;
	logic signed [31:0] x_q;
	logic [AW-1:0]      base_q;
	logic [LW-1:0]      lvl_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      addr;
	logic               we;
	logic signed [31:0] pbm_q, fm_q;
	logic [62:0]        sm_q;
	logic signed [31:0] pbm_r, fm_r;
	logic [62:0]        sm_r;
	logic signed [63:0] sq_s1;
	logic               closed;
	logic [30:0]        mask, pos, nblk;
	logic               div_start, div_done;
	logic signed [65:0] dvd, quo;
	logic [31:0]        dsr;
	logic [1:0]         phase_q;
	logic signed [31:0] wr_pbm;

	assign in_ok = ({30'd0, band_index} < 32'(BANDS)) && ({30'd0, deriv_index} < 32'(DERIVS));
	assign mask  = 31'((32'd1 << lvl_q) - 32'd1);
	assign pos   = ((step_q - 31'd1) & mask) + 31'd1;
	assign closed = (step_q & mask) == 31'd0;
	assign nblk  = ((step_q >> lvl_q) == 31'd0) ? 31'd1 : (step_q >> lvl_q);
	assign addr  = (ctl.clr_write) ? clr_q : AW'(base_q + AW'(lvl_q));
	assign we    = ctl.clr_write || (ctl.cmd == bma_pkg::CMD_WRITE);
	assign wr_pbm = ctl.clr_write ? 32'sd0 : (closed ? 32'sd0 : pbm_q);

	bma_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pbm (.clk, .we, .addr,
		.wdata(wr_pbm), .rdata(pbm_r));
	bma_ram #(.WIDTH(32), .DEPTH(CELLS)) u_fm (.clk, .we, .addr,
		.wdata(ctl.clr_write ? 32'd0 : fm_q), .rdata(fm_r));
	bma_ram #(.WIDTH(63), .DEPTH(CELLS)) u_sm (.clk, .we, .addr,
		.wdata(ctl.clr_write ? 63'd0 : sm_q), .rdata(sm_r));

	// pick dividend and divisor by which quantity is being updated
	always_comb begin
		unique case (phase_q)
			2'd0: begin
				dvd = 66'(x_q) - 66'(pbm_r);
				dsr = {1'b0, pos};
			end
			2'd1: begin
				dvd = 66'(pbm_q) - 66'(fm_r);
				dsr = {1'b0, nblk};
			end
			default: begin
				dvd = 66'(sq_s1) - $signed({3'b000, sm_r});
				dsr = {1'b0, nblk};
			end
		endcase
	end

	assign div_start = ctl.div_start;

	bma_div u_div (.clk, .arst_n, .start(div_start), .dividend(dvd), .divisor(dsr),
		.quotient(quo), .done(div_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			lvl_q     <= '0;
			phase_q   <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.clr_write) begin
				clr_q <= clr_q + AW'(1);
			end
			// raise on a new result, drop once the receiver takes it
			if (ctl.cmd == bma_pkg::CMD_WRITE) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (ctl.cmd)
				bma_pkg::CMD_LOAD: begin
					lvl_q   <= '0;
					phase_q <= 2'd0;
				end
				bma_pkg::CMD_READ:  phase_q <= 2'd0;
				bma_pkg::CMD_PBM:   phase_q <= 2'd1;
				bma_pkg::CMD_FM:    phase_q <= 2'd2;
				default: ;
			endcase
			if (ctl.next_level) begin
				lvl_q <= lvl_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			bma_pkg::CMD_LOAD: begin
				step_q <= step_number;
				x_q    <= sample_value;
				base_q <= AW'((32'(band_index) * 32'(DERIVS) + 32'(deriv_index)) * 32'(LEVELS));
			end
			bma_pkg::CMD_PBM: begin
				pbm_q <= 32'(pbm_r + quo);
				fm_q  <= fm_r;
				sm_q  <= sm_r;
			end
			bma_pkg::CMD_FM: fm_q <= 32'(fm_r + quo);
			bma_pkg::CMD_SM: sm_q <= 63'($signed({3'b000, sm_r}) + quo);
			bma_pkg::CMD_WRITE: begin
				out_level  <= 4'(lvl_q);
				out_pbm    <= pbm_q;
				out_closed <= closed;
				out_fm     <= fm_q;
				out_sm     <= sm_q;
				out_last   <= (32'(lvl_q) == 32'(LEVELS - 1));
			end
			default: ;
		endcase
		// square of the block value, registered before the divide
		sq_s1 <= pbm_q * pbm_q;
	end

	assign sts.div_done = div_done;
	assign sts.closed   = closed;
	assign sts.last_lvl = (32'(lvl_q) == 32'(LEVELS - 1));
	assign sts.out_busy = out_valid && !out_ready;
	assign sts.clr_last = (32'(clr_q) == 32'(CELLS - 1));

`ifndef SYNTHESIS
	a_pos_nz: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> dsr != 32'd0) else $error("zero divisor");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pbm)) else $error("result lost");
	a_no_write_clr: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr_write |-> ctl.cmd != bma_pkg::CMD_WRITE) else $error("clear overlap");
`endif
endmodule

// ----- rtl/core/blocking_moment_accumulator_top.sv -----
// Blocking moment accumulator: top level joining controller and datapath.
// Depends on bma_pkg, bma_ctrl, bma_dp.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one sample item: tdata = band_index, deriv_index, step_number,
//   sample_value (lowest bits first). Each item updates the LEVELS block levels
//   of its channel and yields one result item per level on m_axis, lowest level
//   first; tlast marks the highest level.
//   An item whose channel is out of range is taken and yields nothing.
//   Per level the shared restoring divider (65 bit steps) runs once, or three
//   times on a closing level. Level 0 closes on every item, and the next item
//   is taken once the controller has passed from writing the last result
//   through its emit state back to idle.
//   One item is worked on at a time; s_axis_tready is high only when idle.
//   After reset the state memories are cleared, one entry a cycle, all
//   BANDS*DERIVS*LEVELS entries (256 by default); no item is taken meanwhile.
//   A result waits in the output register while the receiver stalls; the
//   controller holds before writing the next level until it is taken.
module blocking_moment_accumulator_top #(
	parameter int BANDS  = bma_pkg::BANDS_DEF,
	parameter int DERIVS = bma_pkg::DERIVS_DEF,
	parameter int LEVELS = bma_pkg::LEVELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// band_index[1:0], deriv_index[3:2], step_number[34:4], sample_value[66:35]
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level[3:0], running_block_mean[35:4], block_closed[36], mean_estimate[68:37],
	// square_mean_estimate[131:69]
	output logic [135:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	bma_pkg::ctl_t ctl;
	bma_pkg::sts_t sts;
	logic          idle, in_ok, in_fire;
	logic [3:0]          lvl;
	logic signed [31:0]  pbm, fm;
	logic                cl;
	logic [62:0]         sm;

	assign s_axis_tready = idle;
	assign in_fire       = s_axis_tvalid && idle;

	bma_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_ok, .sts, .ctl, .idle);

	bma_dp #(.BANDS(BANDS), .DERIVS(DERIVS), .LEVELS(LEVELS)) u_dp (
		.clk, .arst_n, .ctl, .sts,
		.band_index(s_axis_tdata[1:0]), .deriv_index(s_axis_tdata[3:2]),
		.step_number(s_axis_tdata[34:4]), .sample_value(s_axis_tdata[66:35]),
		.in_ok, .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_level(lvl), .out_pbm(pbm), .out_closed(cl), .out_fm(fm),
		.out_sm(sm), .out_last(m_axis_tlast));

	assign m_axis_tdata = {4'd0, sm, fm, cl, pbm, lvl};
endmodule

// ----- tb/blocking_moment_accumulator_top_tb.sv -----
// Testbench for blocking_moment_accumulator_top: drives sample items on s_axis and checks
// every per-level result on m_axis against a behavioural model of the blocking analysis.
// Depends on bma_pkg and the blocking_moment_accumulator_top RTL.
`timescale 1ns / 1ps
module blocking_moment_accumulator_top_tb;
	localparam int NBANDS  = bma_pkg::BANDS_DEF;
	localparam int NDERIVS = bma_pkg::DERIVS_DEF;
	localparam int NLEVELS = bma_pkg::LEVELS_DEF;
	localparam int NCHAN   = NBANDS * NDERIVS;
	localparam int IDLE_LIMIT = 20000;
	localparam int NRANDOM = 90;

	typedef struct {
		logic [3:0]         level;
		logic signed [31:0] block_mean;
		logic               closed;
		logic signed [31:0] mean_est;
		logic [62:0]        sq_mean_est;
		logic               last;
	} level_result_t;

	typedef struct {
		logic [1:0]         band;
		logic [1:0]         deriv;
		logic [30:0]        step;
		logic signed [31:0] sample;
		bit                 typed;
		logic signed [31:0] lvl0_mean;
		logic [62:0]        lvl0_sq;
	} sample_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic         m_axis_tlast;

	blocking_moment_accumulator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always #6 clk = ~clk;

	logic signed [31:0] block_mean_mem [NCHAN*NLEVELS];
	logic signed [31:0] mean_mem       [NCHAN*NLEVELS];
	logic [62:0]        sq_mean_mem    [NCHAN*NLEVELS];
	level_result_t      expected_levels[$];
	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int closures_seen = 0;
	int idle_cycles = 0;

	// Update one channel across every level and queue the results it yields.
	function automatic void predict_levels(sample_row_t r);
		int unsigned        base;
		int unsigned        idx;
		logic [30:0]        step_m1;
		longint             pos, nblk, pbm, sq;
		level_result_t      res;
		base = (int'(r.band) * NDERIVS + int'(r.deriv)) * NLEVELS;
		step_m1 = r.step - 31'd1;
		for (int b = 0; b < NLEVELS; b++) begin
			idx = base + b;
			pos = longint'(step_m1 & ((31'd1 << b) - 31'd1)) + 1;
			pbm = longint'(block_mean_mem[idx]) +
				(longint'(r.sample) - longint'(block_mean_mem[idx])) / pos;
			block_mean_mem[idx] = pbm[31:0];
			res.closed = (r.step & ((31'd1 << b) - 31'd1)) == 31'd0;
			if (res.closed) begin
				nblk = longint'(r.step >> b);
				if (nblk == 0)
					nblk = 1;
				sq = pbm * pbm;
				mean_mem[idx] = 32'(longint'(mean_mem[idx]) +
					(pbm - longint'(mean_mem[idx])) / nblk);
				sq_mean_mem[idx] = 63'(longint'(sq_mean_mem[idx]) +
					(sq - longint'(sq_mean_mem[idx])) / nblk);
				block_mean_mem[idx] = '0;
			end
			res.level = b[3:0];
			res.block_mean = pbm[31:0];
			res.mean_est = mean_mem[idx];
			res.sq_mean_est = sq_mean_mem[idx];
			res.last = (b == NLEVELS - 1);
			// hand-computed value overrides the model on the lowest level of typed rows
			if (b == 0 && r.typed) begin
				res.mean_est = r.lvl0_mean;
				res.sq_mean_est = r.lvl0_sq;
			end
			expected_levels.push_back(res);
		end
	endfunction

	// Present one item from the falling edge, hold until taken, then sometimes idle a while.
	task automatic send_sample(sample_row_t r);
		int unsigned roll;
		int          gap;
		s_axis_tdata = {5'd0, r.sample, r.step, r.deriv, r.band};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_levels(r);
		samples_sent++;
		@(negedge clk);
		roll = $urandom_range(99);
		gap = roll < 60 ? 0 : roll < 92 ? $urandom_range(1, 4) : $urandom_range(20, 300);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Receiver: stretches of steady acceptance broken by short and long stalls.
	initial begin
		int unsigned roll;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			roll = $urandom_range(99);
			if (roll < 70) begin
				m_axis_tready = 1'b1;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b0;
				repeat (roll < 95 ? $urandom_range(1, 4) : $urandom_range(20, 150))
					@(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		level_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tdata[36])
				closures_seen++;
			if (expected_levels.size() == 0) begin
				$error("unexpected result item: tdata=%h", m_axis_tdata);
				errors++;
			end else begin
				exp_r = expected_levels.pop_front();
				if (m_axis_tdata[3:0] !== exp_r.level) begin
					$error("level: expected %0d, got %0d", exp_r.level, m_axis_tdata[3:0]);
					errors++;
				end
				if (m_axis_tdata[35:4] !== exp_r.block_mean) begin
					$error("running_block_mean (level %0d): expected %h, got %h",
						exp_r.level, exp_r.block_mean, m_axis_tdata[35:4]);
					errors++;
				end
				if (m_axis_tdata[36] !== exp_r.closed) begin
					$error("block_closed (level %0d): expected %b, got %b",
						exp_r.level, exp_r.closed, m_axis_tdata[36]);
					errors++;
				end
				if (m_axis_tdata[68:37] !== exp_r.mean_est) begin
					$error("mean_estimate (level %0d): expected %h, got %h",
						exp_r.level, exp_r.mean_est, m_axis_tdata[68:37]);
					errors++;
				end
				if (m_axis_tdata[131:69] !== exp_r.sq_mean_est) begin
					$error("square_mean_estimate (level %0d): expected %h, got %h",
						exp_r.level, exp_r.sq_mean_est, m_axis_tdata[131:69]);
					errors++;
				end
				if (m_axis_tlast !== exp_r.last) begin
					$error("last_level (level %0d): expected %b, got %b",
						exp_r.level, exp_r.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d items sent, %0d results pending",
				samples_sent, expected_levels.size());
			$display("blocking_moment_accumulator_top_tb: done, errors");
			$finish;
		end
	end

	sample_row_t directed_rows[] = '{
		// fresh channels after reset: level 0 closes at once with the sample itself
		'{2'd0, 2'd0, 31'd1, 32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF, 63'h3FFFFFFF00000001},
		'{2'd1, 2'd1, 31'd1, 32'sh80000000, 1'b1, 32'sh80000000, 63'h4000000000000000},
		'{2'd3, 2'd2, 31'd1, 32'sh00000000, 1'b1, 32'sh00000000, 63'h0},
		// step zero closes every level, block count taken as one
		'{2'd2, 2'd3, 31'd0, 32'sh00000005, 1'b1, 32'sh00000005, 63'd25},
		'{2'd3, 2'd3, 31'd1, 32'shFFFFFFFF, 1'b1, 32'shFFFFFFFF, 63'd1},
		'{2'd0, 2'd0, 31'd2, 32'sh80000000, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd3, 32'sh12345678, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd4, 32'shEDCBA988, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd5, 32'sh7FFFFFFF, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd6, 32'sh80000000, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd7, 32'sh00000001, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd0, 31'd8, 32'shFFFFFFFF, 1'b0, 32'sh0, 63'h0},
		'{2'd1, 2'd1, 31'd2, 32'sh80000000, 1'b0, 32'sh0, 63'h0},
		'{2'd1, 2'd1, 31'd32768, 32'sh7FFFFFFF, 1'b0, 32'sh0, 63'h0},
		'{2'd1, 2'd1, 31'h7FFF8000, 32'sh80000000, 1'b0, 32'sh0, 63'h0},
		'{2'd2, 2'd0, 31'h7FFFFFFF, 32'sh55555555, 1'b0, 32'sh0, 63'h0},
		'{2'd2, 2'd0, 31'h40000000, 32'shAAAAAAAA, 1'b0, 32'sh0, 63'h0},
		'{2'd0, 2'd3, 31'h2AAAAAAA, 32'sh10000000, 1'b0, 32'sh0, 63'h0},
		'{2'd3, 2'd1, 31'h55555555, 32'shF0000000, 1'b0, 32'sh0, 63'h0},
		'{2'd2, 2'd3, 31'd0, 32'sh80000000, 1'b0, 32'sh0, 63'h0}
	};

	initial begin
		sample_row_t  r;
		logic [30:0]  next_step [NCHAN];
		int unsigned  roll, ch;
		for (int i = 0; i < NCHAN * NLEVELS; i++) begin
			block_mean_mem[i] = '0;
			mean_mem[i] = '0;
			sq_mean_mem[i] = '0;
		end
		for (int i = 0; i < NCHAN; i++)
			next_step[i] = 31'd1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_sample(directed_rows[i]);

		// mostly ordered step sequences per channel, with aligned and wild steps mixed in
		for (int n = 0; n < NRANDOM; n++) begin
			ch = $urandom_range(NCHAN - 1);
			r.band = ch[3:2];
			r.deriv = ch[1:0];
			r.typed = 1'b0;
			r.lvl0_mean = '0;
			r.lvl0_sq = '0;
			roll = $urandom_range(99);
			if (roll < 70) begin
				r.step = next_step[ch];
			end else if (roll < 85) begin
				r.step = 31'($urandom()) & ~((31'd1 << $urandom_range(20)) - 31'd1);
			end else if (roll < 96) begin
				r.step = 31'($urandom());
			end else begin
				r.step = 31'd0;
			end
			next_step[ch] = r.step + 31'd1;
			roll = $urandom_range(99);
			r.sample = roll < 8 ? 32'sh7FFFFFFF : roll < 16 ? 32'sh80000000 : $urandom();
			send_sample(r);
		end
		s_axis_tvalid = 1'b0;

		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);

		$display("covered %0d sample items, %0d level results, %0d of them closing a block",
			samples_sent, results_seen, closures_seen);
		if (errors == 0)
			$display("blocking_moment_accumulator_top_tb: done, clean");
		else
			$display("blocking_moment_accumulator_top_tb: done, errors");
		$finish;
	end
endmodule
